// File: hdl/srt_pkg.sv
`default_nettype none

package srt_pkg;

    localparam int DEF_MAX_SEGMENTS  = 1024;
    localparam int DEF_PAYLOAD_BYTES = 128;
    localparam int WORD_W            = 32;
    localparam int FIFO_DEPTH        = 2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] RANGE_DONE    = 16'hffff;

    typedef enum logic [1:0] {
        OP_REQ  = 2'd0,
        OP_SEG  = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_REQ,
        CMD_BIG,
        CMD_SEG,
        CMD_TICK
    } cmd_kind_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_TOO_LARGE = 3'd1,
        KIND_STORED    = 3'd2,
        KIND_RESEND    = 3'd3,
        KIND_COMPLETE  = 3'd4,
        KIND_RANGE     = 3'd5
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SEG,
        ST_SCAN
    } st_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  ident;
        logic [31:0] num;
        logic [15:0] idx;
        logic        idx_big;
        logic [16:0] addr;
    } cmd_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [7:0]  ident;
        logic [15:0] rs;
        logic [15:0] re;
        logic [16:0] addr;
    } res_t;

    function automatic logic [4:0] ffs32(input logic [WORD_W-1:0] v);
        logic [4:0] r;
        r = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (v[j])
            begin
                r = 5'(j);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/srt_front.sv
`default_nettype none

module srt_front
    import srt_pkg::*;
#(
    parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
)
(
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  file_ident,
    input  wire logic [31:0] file_bytes,
    input  wire logic [15:0] segment_index,
    input  wire logic        q_full,
    output      logic        push,
    output      cmd_t        cmd
);

    localparam int LIMIT = MAX_SEGMENTS * PAYLOAD_BYTES;

    logic [23:0] prod;

    assign in_stall = q_full;
    assign prod     = 24'(segment_index) * 24'(PAYLOAD_BYTES);

    always_comb
    begin
        cmd         = '0;
        push        = 1'b0;
        cmd.ident   = file_ident;
        cmd.num     = file_bytes + 32'(PAYLOAD_BYTES - 1);
        cmd.idx     = segment_index;
        cmd.idx_big = segment_index >= 16'(MAX_SEGMENTS);
        cmd.addr    = prod[16:0];
        unique case (op)
            OP_REQ:
            begin
                cmd.kind = (file_bytes > 32'(LIMIT)) ? CMD_BIG : CMD_REQ;
                push     = in_valid && !q_full;
            end
            OP_SEG:
            begin
                cmd.kind = CMD_SEG;
                push     = in_valid && !q_full;
            end
            OP_TICK:
            begin
                cmd.kind = CMD_TICK;
                push     = in_valid && !q_full;
            end
            default:
            begin
                cmd.kind = CMD_TICK;
                push     = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/srt_fifo.sv
`default_nettype none

module srt_fifo
    import srt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wdata,
    input  wire logic pop,
    output      cmd_t head,
    output      logic full,
    output      logic nonempty
);

    cmd_t       ent_reg [FIFO_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head     = ent_reg[rd_ptr_reg];
    assign full     = count_reg == 2'(FIFO_DEPTH);
    assign nonempty = count_reg != 2'd0;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: hdl/srt_back.sv
`default_nettype none

module srt_back
    import srt_pkg::*;
#(
    parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire cmd_t        head,
    input  wire logic        nonempty,
    output      logic        pop,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      res_t        res
);

    localparam int LIMIT  = MAX_SEGMENTS * PAYLOAD_BYTES;
    localparam int NUM_W  = $clog2(LIMIT + PAYLOAD_BYTES);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH  = (MAX_SEGMENTS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = ((CNT_W > ADDR_W + 5) ? CNT_W : ADDR_W + 5) + 1;
    localparam int L_W    = $clog2(PAYLOAD_BYTES);
    localparam int SHIFT  = NUM_W + L_W;
    localparam int M_W    = NUM_W + 2;
    localparam int P_W    = NUM_W + M_W;
    // ceil(2^SHIFT / PAYLOAD_BYTES), exact quotient for every numerator below 2^NUM_W
    localparam logic [M_W-1:0] RECIP = M_W'(((longint'(1) << SHIFT)
        + longint'(PAYLOAD_BYTES) - longint'(1)) / longint'(PAYLOAD_BYTES));

    st_t               st_reg, st_next;
    cmd_t              cmd_reg, cmd_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic [7:0]        active_reg, active_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  rcv_reg, rcv_next;
    logic [15:0]       timer_reg, timer_next;
    logic              armed_reg, armed_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              found_reg, found_next;
    logic [15:0]       start_reg, start_next;
    logic [15:0]       end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    logic              out_free;
    logic              seg_hit, seg_oor, tick_fire, clr_done;
    logic [15:0]       tick_cnt;
    logic [P_W-1:0]    qprod;
    logic [CNT_W-1:0]  quot;
    logic [CW-1:0]     base, tot, diff;
    logic [WORD_W-1:0] mask, z, t;
    logic [4:0]        s;
    logic              last, found_now, hit_end, finish, bit_set;
    logic [15:0]       start_cand, end_cand;
    logic [CNT_W-1:0]  rcv_inc;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (st_reg == ST_IDLE) && nonempty && out_free;

    always_comb
    begin
        seg_hit   = head.ident == active_reg;
        seg_oor   = head.idx_big || (head.idx >= 16'(total_reg));
        tick_cnt  = timer_reg + 16'd1;
        tick_fire = armed_reg && !(tick_cnt < timeout_reg);
        clr_done  = ptr_reg == ADDR_W'(DEPTH - 1);
        qprod     = P_W'(num_reg) * P_W'(RECIP);
        quot      = CNT_W'(qprod >> SHIFT);
        base      = CW'({ptr_reg, 5'b0});
        tot       = CW'(total_reg);
        diff      = tot - base;
        if (tot <= base)
        begin
            mask = '0;
        end
        else if (diff >= CW'(WORD_W))
        begin
            mask = '1;
        end
        else
        begin
            mask = (WORD_W'(1) << diff[4:0]) - WORD_W'(1);
        end
        last       = (base + CW'(WORD_W)) >= tot;
        z          = ~rdata_reg & mask;
        s          = ffs32(z);
        found_now  = found_reg || (z != '0);
        t          = found_reg ? (rdata_reg & mask)
                               : (rdata_reg & mask & ~((WORD_W'(1) << s) - WORD_W'(1)));
        start_cand = found_reg ? start_reg : (16'(base) + 16'(s));
        hit_end    = found_now && (t != '0);
        end_cand   = 16'(base) + 16'(ffs32(t)) - 16'd1;
        finish     = hit_end || last;
        bit_set    = rdata_reg[cmd_reg.idx[4:0]];
        rcv_inc    = bit_set ? rcv_reg : rcv_reg + CNT_W'(1);
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.kind)
                        CMD_REQ:  st_next = ST_DIV;
                        CMD_SEG:  st_next = (seg_hit && !seg_oor) ? ST_SEG : ST_IDLE;
                        CMD_TICK: st_next = tick_fire ? ST_SCAN : ST_IDLE;
                        default:  st_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                st_next = ST_CLEAR;
            end
            ST_SEG:
            begin
                st_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        timeout_next   = cfg_wr_en ? cfg_wr_data : timeout_reg;
        active_next    = active_reg;
        total_next     = total_reg;
        rcv_next       = rcv_reg;
        timer_next     = timer_reg;
        armed_next     = armed_reg;
        num_next       = num_reg;
        ptr_next       = ptr_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = '0;
        mem_raddr      = ptr_reg + ADDR_W'(1);
        unique case (st_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = clr_done ? '0 : ptr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next = head;
                    case (head.kind)
                        CMD_BIG:
                        begin
                            out_valid_next = 1'b1;
                            res_next       = '0;
                            res_next.kind  = KIND_TOO_LARGE;
                            res_next.ident = head.ident;
                        end
                        CMD_REQ:
                        begin
                            num_next = NUM_W'(head.num);
                        end
                        CMD_SEG:
                        begin
                            if (seg_hit && seg_oor)
                            begin
                                out_valid_next = 1'b1;
                                res_next       = '0;
                                res_next.kind  = KIND_RANGE;
                                res_next.ident = active_reg;
                            end
                            mem_raddr = ADDR_W'(head.idx >> 5);
                        end
                        default:
                        begin
                            if (armed_reg)
                            begin
                                if (tick_fire)
                                begin
                                    timer_next = '0;
                                    mem_raddr  = '0;
                                    ptr_next   = '0;
                                    found_next = 1'b0;
                                    start_next = '0;
                                    end_next   = 16'(total_reg) - 16'd1;
                                end
                                else
                                begin
                                    timer_next = tick_cnt;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                active_next    = cmd_reg.ident;
                total_next     = quot;
                rcv_next       = '0;
                timer_next     = '0;
                armed_next     = 1'b0;
                ptr_next       = '0;
                out_valid_next = 1'b1;
                res_next       = '0;
                res_next.kind  = KIND_ACCEPTED;
                res_next.ident = cmd_reg.ident;
            end
            ST_SEG:
            begin
                mem_we         = 1'b1;
                mem_waddr      = ADDR_W'(cmd_reg.idx >> 5);
                mem_wdata      = rdata_reg | (WORD_W'(1) << cmd_reg.idx[4:0]);
                rcv_next       = rcv_inc;
                timer_next     = '0;
                out_valid_next = 1'b1;
                res_next       = '0;
                res_next.ident = active_reg;
                res_next.addr  = cmd_reg.addr;
                if (rcv_inc >= total_reg)
                begin
                    armed_next    = 1'b0;
                    res_next.kind = KIND_COMPLETE;
                    res_next.rs   = RANGE_DONE;
                    res_next.re   = RANGE_DONE;
                end
                else
                begin
                    armed_next    = 1'b1;
                    res_next.kind = KIND_STORED;
                end
            end
            ST_SCAN:
            begin
                ptr_next   = ptr_reg + ADDR_W'(1);
                found_next = found_now;
                start_next = found_now ? start_cand : start_reg;
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.kind  = KIND_RESEND;
                    res_next.ident = active_reg;
                    res_next.rs    = found_now ? start_cand : start_reg;
                    res_next.re    = hit_end ? end_cand : end_reg;
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            timeout_reg   <= TIMEOUT_RESET;
            active_reg    <= '0;
            total_reg     <= '0;
            rcv_reg       <= '0;
            timer_reg     <= '0;
            armed_reg     <= 1'b0;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            timeout_reg   <= timeout_next;
            active_reg    <= active_next;
            total_reg     <= total_next;
            rcv_reg       <= rcv_next;
            timer_reg     <= timer_next;
            armed_reg     <= armed_next;
            ptr_reg       <= ptr_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        num_reg   <= num_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        res_reg   <= res_next;
    end

    // bitmap words, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/segment_reassembly_tracker_top.sv
// request: queue pop, then the reciprocal-multiply divide with its result, then a bitmap
//   clear before the next beat is taken; too large and out of range: reply on the queue pop
// segment: queue pop with bitmap word read, then word write with result; next pop waits for it
// timeout: queue pop with first bitmap word read, then a scan of the 32-segment bitmap words
//   up to the end of the missing run; reset: control cleared at once, then a bitmap clear
// input beats queue in a 2-entry buffer while the bitmap is busy
`default_nettype none

module segment_reassembly_tracker_top
    import srt_pkg::*;
#(
    parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  file_ident,
    input  wire logic [31:0] file_bytes,
    input  wire logic [15:0] segment_index,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [2:0]  kind,
    output      logic [7:0]  reply_ident,
    output      logic [15:0] range_start,
    output      logic [15:0] range_end,
    output      logic [16:0] write_address
);

    cmd_t cmd, head;
    res_t res;
    logic push, pop, q_full, q_nonempty;

    srt_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .file_ident   (file_ident),
        .file_bytes   (file_bytes),
        .segment_index(segment_index),
        .q_full       (q_full),
        .push         (push),
        .cmd          (cmd)
    );

    srt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wdata   (cmd),
        .pop     (pop),
        .head    (head),
        .full    (q_full),
        .nonempty(q_nonempty)
    );

    srt_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .head       (head),
        .nonempty   (q_nonempty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    assign kind          = res.kind;
    assign reply_ident   = res.ident;
    assign range_start   = res.rs;
    assign range_end     = res.re;
    assign write_address = res.addr;

endmodule

`default_nettype wire

// File: hdl/srt_checker.sv
`default_nettype none

module srt_checker
    import srt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  kind,
    input wire logic [15:0] range_start,
    input wire logic [15:0] range_end,
    input wire logic [16:0] write_address
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(range_start))
        else $error("stalled result beat changed");

    a_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_COMPLETE |-> range_start == RANGE_DONE
            && range_end == RANGE_DONE)
        else $error("completion without full range marker");

    a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ACCEPTED || kind == KIND_TOO_LARGE
            || kind == KIND_RANGE) |-> write_address == '0 && range_start == '0
            && range_end == '0)
        else $error("reply carries stray range or address");

    a_resend_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RESEND && range_start != '0
            |-> range_end >= range_start)
        else $error("resend run ends before it starts");

endmodule

bind segment_reassembly_tracker_top srt_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .range_start  (range_start),
    .range_end    (range_end),
    .write_address(write_address)
);

`default_nettype wire

// File: bench/segment_reassembly_tracker_top_test.sv
`default_nettype none

module segment_reassembly_tracker_top_test;
    import srt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int SEG_LIMIT = DEF_MAX_SEGMENTS;
    localparam int SEG_BYTES = DEF_PAYLOAD_BYTES;
    localparam int SETTLE_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_TICK;
    logic [7:0]  file_ident = '0;
    logic [31:0] file_bytes = '0;
    logic [15:0] segment_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  reply_ident;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic [16:0] write_address;

    // tracker state as predicted
    logic [15:0]         timeout_val = TIMEOUT_RESET;
    logic [7:0]          cur_ident = '0;
    int                  seg_count = 0;
    logic [SEG_LIMIT-1:0] seg_seen = '0;
    int                  seen_count = 0;
    logic [15:0]         tick_count = '0;
    bit                  timer_on = 1'b0;

    res_t pending_replies[$];
    int   fail_count = 0;
    bit   calm = 1'b0;
    int   hold_left = 0;

    segment_reassembly_tracker_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .file_ident(file_ident), .file_bytes(file_bytes),
        .segment_index(segment_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .reply_ident(reply_ident), .range_start(range_start),
        .range_end(range_end), .write_address(write_address)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic void push_reply(res_kind_t k, logic [7:0] id, logic [15:0] rs,
                                       logic [15:0] re, logic [16:0] addr);
        res_t r;
        r.kind = k;
        r.ident = id;
        r.rs = rs;
        r.re = re;
        r.addr = addr;
        pending_replies.push_back(r);
    endfunction

    function automatic void track_beat(logic [1:0] o, logic [7:0] id, logic [31:0] nb,
                                       logic [15:0] idx);
        longint segs;
        logic [15:0] gs;
        logic [15:0] ge;
        bit found;
        if (o == OP_REQ)
        begin
            segs = (longint'(nb) + SEG_BYTES - 1) / SEG_BYTES;
            if (segs > SEG_LIMIT)
            begin
                push_reply(KIND_TOO_LARGE, id, '0, '0, '0);
                return;
            end
            cur_ident = id;
            seg_count = int'(segs);
            seg_seen = '0;
            seen_count = 0;
            tick_count = '0;
            timer_on = 1'b0;
            push_reply(KIND_ACCEPTED, id, '0, '0, '0);
        end
        else if (o == OP_SEG)
        begin
            if (id != cur_ident)
                return;
            if (int'(idx) >= seg_count)
            begin
                push_reply(KIND_RANGE, cur_ident, '0, '0, '0);
                return;
            end
            if (!seg_seen[idx])
            begin
                seg_seen[idx] = 1'b1;
                seen_count++;
            end
            tick_count = '0;
            if (seen_count >= seg_count)
            begin
                timer_on = 1'b0;
                push_reply(KIND_COMPLETE, cur_ident, RANGE_DONE, RANGE_DONE,
                           17'(int'(idx) * SEG_BYTES));
            end
            else
            begin
                timer_on = 1'b1;
                push_reply(KIND_STORED, cur_ident, '0, '0, 17'(int'(idx) * SEG_BYTES));
            end
        end
        else if (o == OP_TICK)
        begin
            if (!timer_on)
                return;
            tick_count = tick_count + 16'd1;
            if (tick_count < timeout_val)
                return;
            tick_count = '0;
            gs = '0;
            ge = 16'(seg_count - 1);
            found = 1'b0;
            for (int i = 0; i < seg_count; i++)
            begin
                if (!found && !seg_seen[i])
                begin
                    gs = 16'(i);
                    found = 1'b1;
                end
                if (found && seg_seen[i])
                begin
                    ge = 16'(i - 1);
                    break;
                end
            end
            push_reply(KIND_RESEND, cur_ident, gs, ge, '0);
        end
    endfunction

    // reply checker
    always @(posedge clk)
    begin
        res_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected beat: kind %0d ident %0d", $realtime, kind,
                         reply_ident);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (kind != want.kind || reply_ident != want.ident ||
                    range_start != want.rs || range_end != want.re ||
                    write_address != want.addr)
                begin
                    $display("%0t mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                             $realtime, want.kind, want.ident, want.rs, want.re, want.addr,
                             kind, reply_ident, range_start, range_end, write_address);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 35);
        end
    end

    task automatic send_beat(logic [1:0] o, logic [7:0] id, logic [31:0] nb,
                             logic [15:0] idx);
        if (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        file_ident <= id;
        file_bytes <= nb;
        segment_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        track_beat(o, id, nb, idx);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        timeout_val = v;
    endtask

    // one file transfer: request, shuffled segments with drops, ticks and noise
    task automatic run_transfer(int max_segs);
        logic [7:0] id;
        logic [31:0] nb;
        int n;
        id = 8'($urandom);
        nb = $urandom_range(1, max_segs * SEG_BYTES);
        send_beat(OP_REQ, id, nb, '0);
        n = (int'(nb) + SEG_BYTES - 1) / SEG_BYTES;
        for (int k = 0; k < n + n / 2 + 2; k++)
        begin
            case ($urandom_range(9))
                0, 1: send_beat(OP_TICK, 8'($urandom), $urandom, 16'($urandom));
                2: send_beat(OP_SEG, 8'($urandom), $urandom, 16'($urandom_range(n)));
                3: send_beat(OP_SEG, id, $urandom, 16'($urandom));
                default: send_beat(OP_SEG, id, $urandom, 16'($urandom_range(n - 1)));
            endcase
        end
        for (int k = 0; k < 4; k++)
            send_beat(OP_TICK, id, '0, '0);
    endtask

    task automatic test_directed;
        send_beat(OP_TICK, 8'h00, '0, '0);
        send_beat(OP_NONE, 8'hff, 32'hffffffff, 16'hffff);
        send_beat(OP_REQ, 8'h5a, 32'hffffffff, '0);
        send_beat(OP_REQ, 8'h11, 32'd131073, '0);
        send_beat(OP_REQ, 8'h11, 32'd0, '0);
        send_beat(OP_SEG, 8'h11, '0, 16'd0);
        send_beat(OP_REQ, 8'hff, 32'd131072, '0);
        send_beat(OP_SEG, 8'hff, '0, 16'd1023);
        send_beat(OP_SEG, 8'hff, '0, 16'd1024);
        send_beat(OP_SEG, 8'hff, '0, 16'hffff);
        send_beat(OP_REQ, 8'h00, 32'd300, '0);
        send_beat(OP_SEG, 8'h01, '0, 16'd0);
        send_beat(OP_SEG, 8'h00, '0, 16'd1);
        send_beat(OP_TICK, 8'h00, '0, '0);
        send_beat(OP_SEG, 8'h00, '0, 16'd1);
        send_beat(OP_TICK, 8'h00, '0, '0);
        send_beat(OP_SEG, 8'h00, '0, 16'd0);
        send_beat(OP_SEG, 8'h00, '0, 16'd2);
        send_beat(OP_SEG, 8'h00, '0, 16'd2);
        send_beat(OP_TICK, 8'h00, '0, '0);
        send_beat(OP_NONE, 8'h00, '0, 16'd0);
    endtask

    task automatic test_random(int transfers, int max_segs);
        for (int t = 0; t < transfers; t++)
            run_transfer(max_segs);
    endtask

    task automatic test_backpressure;
        hold_left = 300;
        for (int k = 0; k < 30; k++)
            send_beat(k % 3 == 0 ? OP_REQ : OP_TICK, 8'h3c, $urandom_range(1, 4096), '0);
        drain();
        run_transfer(12);
    endtask

    task automatic test_big_file;
        send_beat(OP_REQ, 8'h77, 32'd131000, '0);
        for (int k = 0; k < 40; k++)
            send_beat(k % 4 == 0 ? OP_TICK : OP_SEG, 8'h77, '0, 16'($urandom_range(1023)));
        send_beat(OP_SEG, 8'h77, '0, 16'd0);
        send_beat(OP_TICK, 8'h77, '0, '0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        drain();
        test_directed();
        set_timeout(16'd1);
        test_directed();
        test_random(4, 16);
        set_timeout(16'd0);
        test_random(3, 10);
        set_timeout(16'd3);
        calm = 1'b1;
        test_random(4, 12);
        calm = 1'b0;
        test_backpressure();
        set_timeout(16'd1);
        test_big_file();
        set_timeout(16'hffff);
        test_random(2, 8);
        set_timeout(16'd2);
        test_random(5, 20);
        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
